// File: src/fdcd_pkg.sv
// Shared constants, codes and frame encoding for the flip-dot column driver.
`timescale 1ns / 1ps
`default_nettype none

package fdcd_pkg;

  // Display geometry
  localparam int COLUMNS = 21;
  localparam int ROWS    = 13;
  localparam int COL_W   = 5;
  localparam int ROW_W   = 4;
  localparam int PHYS_W  = 5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_ADDRESS = 2'd2;

  // Register reset values
  localparam logic [3:0] ROW_OFFSET_RST    = 4'd6;
  localparam logic [2:0] COLUMN_OFFSET_RST = 3'd7;
  localparam logic [7:0] BOARD_ADDRESS_RST = 8'd1;

  // Input commands
  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_FORCE = 1'b1;

  // Frame phases
  localparam logic [1:0] PH_DATA    = 2'd0;
  localparam logic [1:0] PH_ENABLE  = 2'd1;
  localparam logic [1:0] PH_RELEASE = 2'd2;

  // Frame byte constants
  localparam logic [7:0] B1_BASE        = 8'h7c;
  localparam logic [7:0] ROW_GROUP_MASK = 8'b01111111;
  localparam logic [7:0] ADDR_LSB_MASK  = 8'h01;
  localparam logic [2:0] SEG_MASK       = 3'b111;
  localparam logic [1:0] DIGIT_MASK     = 2'b11;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch_in;
    logic       prep;
    logic       emit;
    logic [1:0] phase;
  } fdcd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic col_ok;
    logic flips_none;
    logic one_left;
    logic slot_free;
  } fdcd_sts_t;

  // Quotient of a physical column by seven
  function automatic logic [1:0] div7(input logic [PHYS_W-1:0] p);
    logic [1:0] q;
    if (p >= PHYS_W'(21))      q = 2'd3;
    else if (p >= PHYS_W'(14)) q = 2'd2;
    else if (p >= PHYS_W'(7))  q = 2'd1;
    else                       q = 2'd0;
    return q;
  endfunction

  // Index of the lowest set bit
  function automatic logic [ROW_W-1:0] lowest_row(input logic [ROWS-1:0] m);
    logic [ROW_W-1:0] idx;
    idx = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (m[i]) idx = ROW_W'(i);
    end
    return idx;
  endfunction

  // Build one 64-bit shift register frame
  function automatic logic [63:0] make_frame(input logic [PHYS_W-1:0] prow,
                                             input logic [PHYS_W-1:0] pcol,
                                             input logic              dir,
                                             input logic              enable,
                                             input logic [7:0]        addr);
    logic [31:0] r;
    logic [4:0]  c;
    logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
    logic [7:0]  g_lo, g_mid, g_hi;
    r  = 32'd1 << prow;
    c  = pcol + 5'd1 + {3'b0, div7(pcol)};
    b0 = '0; b2 = '0; b3 = '0; b4 = '0; b5 = '0; b6 = '0; b7 = '0;
    b1 = B1_BASE & ~({5'b0, c[2:0] & SEG_MASK} << 2)
                 & ~({6'b0, c[4:3] & DIGIT_MASK} << 5);
    b1 = b1 | {6'b0, dir, 1'b0};
    g_lo  = {r[6:0]   & ROW_GROUP_MASK[6:0], 1'b0};
    g_mid = {r[13:7]  & ROW_GROUP_MASK[6:0], 1'b0};
    g_hi  = {r[20:14] & ROW_GROUP_MASK[6:0], 1'b0};
    if (dir) begin
      b5 = g_hi; b6 = g_mid; b7 = g_lo;
    end else begin
      b2 = g_hi; b3 = g_mid; b4 = g_lo;
    end
    if (enable) begin
      b1 = b1 | {addr[0], 7'b0};
      b0 = addr & ~ADDR_LSB_MASK;
    end
    return {b0, b1, b2, b3, b4, b5, b6, b7};
  endfunction

endpackage

`default_nettype wire

// File: src/fdcd_ctrl.sv
// Controller state machine: accepts items and sequences the three frames of each flip.
`timescale 1ns / 1ps
`default_nettype none

module fdcd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fdcd_pkg::fdcd_sts_t sts,
  output fdcd_pkg::fdcd_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMIT
  } state_t;

  state_t     state;
  logic [1:0] phase;

  // Decode commands from the current state
  always_comb begin
    in_ready     = (state == ST_IDLE);
    cmd.latch_in = (state == ST_IDLE) && in_valid;
    cmd.prep     = (state == ST_PREP) && sts.col_ok;
    cmd.emit     = (state == ST_EMIT) && sts.slot_free;
    cmd.phase    = phase;
  end

  // Hold state and phase counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= fdcd_pkg::PH_DATA;
    end else begin
      case (state)
        ST_IDLE: begin
          phase <= fdcd_pkg::PH_DATA;
          if (in_valid) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          // Drop out-of-range columns and sets that change nothing
          if (sts.col_ok && !sts.flips_none) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (sts.slot_free) begin
            if (phase == fdcd_pkg::PH_RELEASE) begin
              phase <= fdcd_pkg::PH_DATA;
              if (sts.one_left) begin
                state <= ST_IDLE;
              end
            end else begin
              phase <= phase + 2'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          phase <= fdcd_pkg::PH_DATA;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/fdcd_dpath.sv
// Datapath: configuration, dot image, flip mask and the output frame register.
`timescale 1ns / 1ps
`default_nettype none

module fdcd_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  input  wire logic [fdcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [7:0]                           cfg_data,
  input  wire logic                                 command,
  input  wire logic [fdcd_pkg::COL_W-1:0]           column,
  input  wire logic [fdcd_pkg::ROWS-1:0]            pattern,
  input  wire logic                                 level,
  input  wire fdcd_pkg::fdcd_cmd_t                  cmd,
  output fdcd_pkg::fdcd_sts_t                       sts,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [63:0]                               frame,
  output logic [1:0]                                phase,
  output logic [fdcd_pkg::ROW_W-1:0]                flip_row,
  output logic                                      flip_level,
  output logic                                      last
);

  // Configuration registers
  logic [3:0] row_off;
  logic [2:0] col_off;
  logic [7:0] board_addr;

  // Latched input item
  logic                         cmd_q;
  logic [fdcd_pkg::COL_W-1:0]   col_q;
  logic [fdcd_pkg::ROWS-1:0]    pat_q;
  logic                         lvl_q;

  // Dot image and the flip in progress
  logic [fdcd_pkg::ROWS-1:0] image [fdcd_pkg::COLUMNS];
  logic [fdcd_pkg::ROWS-1:0] flips;
  logic [fdcd_pkg::ROWS-1:0] target;

  logic [fdcd_pkg::ROWS-1:0]   old_col;
  logic [fdcd_pkg::ROWS-1:0]   target_next;
  logic [fdcd_pkg::ROWS-1:0]   flips_next;
  logic [fdcd_pkg::ROW_W-1:0]  cur_row;
  logic [fdcd_pkg::PHYS_W-1:0] prow;
  logic [fdcd_pkg::PHYS_W-1:0] pcol;
  logic                        cur_dir;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_off    <= fdcd_pkg::ROW_OFFSET_RST;
      col_off    <= fdcd_pkg::COLUMN_OFFSET_RST;
      board_addr <= fdcd_pkg::BOARD_ADDRESS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fdcd_pkg::REG_ROW_OFFSET:    row_off    <= cfg_data[3:0];
        fdcd_pkg::REG_COLUMN_OFFSET: col_off    <= cfg_data[2:0];
        fdcd_pkg::REG_BOARD_ADDRESS: board_addr <= cfg_data;
        default: ;
      endcase
    end
  end

  // Work out target and flip mask for the latched item
  always_comb begin
    sts.col_ok  = (col_q < fdcd_pkg::COL_W'(fdcd_pkg::COLUMNS));
    old_col     = sts.col_ok ? image[col_q] : '0;
    if (cmd_q == fdcd_pkg::CMD_FORCE) begin
      target_next = lvl_q ? '1 : '0;
      flips_next  = '1;
    end else begin
      target_next = pat_q;
      flips_next  = old_col ^ pat_q;
    end
    sts.flips_none = (flips_next == '0);
    sts.one_left   = ((flips & (flips - fdcd_pkg::ROWS'(1))) == '0);
    sts.slot_free  = !out_valid || out_ready;
  end

  // Encode the current flip
  always_comb begin
    cur_row = fdcd_pkg::lowest_row(flips);
    cur_dir = target[cur_row];
    prow    = {1'b0, cur_row} + {1'b0, row_off};
    pcol    = col_q + {2'b0, col_off};
  end

  // Update image, load and advance flip mask
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fdcd_pkg::COLUMNS; i++) begin
        image[i] <= '0;
      end
      flips <= '0;
    end else begin
      if (cmd.prep) begin
        image[col_q] <= target_next;
        flips        <= flips_next;
      end else if (cmd.emit && (cmd.phase == fdcd_pkg::PH_RELEASE)) begin
        flips <= flips & (flips - fdcd_pkg::ROWS'(1));
      end
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_q <= command;
      col_q <= column;
      pat_q <= pattern;
      lvl_q <= level;
    end
    if (cmd.prep) begin
      target <= target_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      frame      <= fdcd_pkg::make_frame(prow, pcol, cur_dir,
                                         cmd.phase == fdcd_pkg::PH_ENABLE, board_addr);
      phase      <= cmd.phase;
      flip_row   <= cur_row;
      flip_level <= cur_dir;
      last       <= sts.one_left && (cmd.phase == fdcd_pkg::PH_RELEASE);
    end
  end

endmodule

`default_nettype wire

// File: src/flip_dot_column_diff_driver.sv
// Top level of the flip-dot column driver: controller and datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) transfers one column command: set the
//   column to a pattern (only differing dots flip) or force all rows to a level.
//   Output channel (out_valid/out_ready) transfers one 64-bit frame per flip
//   phase: data load, enable asserted, enable released, rows in ascending order.
//   last marks the final frame of an item. Out-of-range columns and sets that
//   change nothing produce no frames.
//   Config channel (cfg_valid/cfg_ready) writes row offset, column offset and
//   board address; cfg_ready is always high. Write only while idle.
// Timing:
//   An item is accepted in the idle state, its image column is read in the prep
//   state, then the output register takes one frame per cycle while the
//   receiver does not stall. in_ready rises when the last frame enters the
//   output register, so the next item is taken while that frame still waits.
//   A stalled receiver holds the frame sequencer.
// Reset:
//   Clears the dot image, loads register defaults and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module flip_dot_column_diff_driver (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fdcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           command,
  input  wire logic [fdcd_pkg::COL_W-1:0]     column,
  input  wire logic [fdcd_pkg::ROWS-1:0]      pattern,
  input  wire logic                           level,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [63:0]                         frame,
  output logic [1:0]                          phase,
  output logic [fdcd_pkg::ROW_W-1:0]          flip_row,
  output logic                                flip_level,
  output logic                                last
);

  fdcd_pkg::fdcd_cmd_t cmd;
  fdcd_pkg::fdcd_sts_t sts;

  assign cfg_ready = 1'b1;

  fdcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fdcd_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .command    (command),
    .column     (column),
    .pattern    (pattern),
    .level      (level),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame      (frame),
    .phase      (phase),
    .flip_row   (flip_row),
    .flip_level (flip_level),
    .last       (last)
  );

`ifndef SYNTHESIS
  // The final frame of an item is always the enable release
  a_last_is_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (phase == fdcd_pkg::PH_RELEASE))
    else $error("last set on a frame that is not the release phase");

  // Address byte appears only on the enable frame
  a_addr_only_enable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (phase != fdcd_pkg::PH_ENABLE)) |-> (frame[63:56] == 8'h00))
    else $error("address byte set outside the enable phase");

  // One item at a time: no second transfer right after an accepted item
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");
`endif

endmodule

`default_nettype wire

// File: dv/flip_dot_column_diff_driver_tb.sv
// Self-checking testbench for the flip-dot column driver with a frame predictor class.
`timescale 1ns / 1ps

module flip_dot_column_diff_driver_tb;
  import fdcd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [63:0]      frame;
    logic [1:0]       phase;
    logic [ROW_W-1:0] row;
    logic             dir;
    logic             last;
  } frame_rec_t;

  // Predict the frames of each column command and check them in order
  class column_frame_predictor;
    logic [3:0]      row_off;
    logic [2:0]      col_off;
    logic [7:0]      addr;
    logic [ROWS-1:0] image [COLUMNS];
    frame_rec_t      frames_due [$];
    int errors, frames_seen, sets, forces, ignored;

    function new();
      row_off = ROW_OFFSET_RST;
      col_off = COLUMN_OFFSET_RST;
      addr    = BOARD_ADDRESS_RST;
      foreach (image[i]) image[i] = '0;
      errors = 0; frames_seen = 0; sets = 0; forces = 0; ignored = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        REG_ROW_OFFSET:    row_off = data[3:0];
        REG_COLUMN_OFFSET: col_off = data[2:0];
        REG_BOARD_ADDRESS: addr = data;
        default: ;
      endcase
    endfunction

    // Byte 0 is sent first and lands in bits 63..56
    function logic [63:0] build_frame(logic [4:0] row, logic dir, logic en, logic [4:0] col);
      logic [7:0]      pcol, c, prow;
      logic [31:0]     onehot;
      logic [0:7][7:0] b;
      int              base;
      pcol   = 8'(col) + 8'(col_off);
      c      = pcol + 8'd1 + pcol / 8'd7;
      prow   = 8'(row) + 8'(row_off);
      onehot = (prow < 8'd32) ? (32'd1 << prow) : 32'd0;
      b      = '0;
      // segment in bits 4..2, low digit bits in 6..5, both active low
      b[1]    = B1_BASE & ~({5'b0, c[2:0]} << 2) & ~({6'b0, c[4:3]} << 5);
      b[1][1] = dir;
      // shown dots drive the anode group, dark dots the cathode group
      base        = dir ? 5 : 2;
      b[base + 2] = {onehot[6:0], 1'b0};
      b[base + 1] = {onehot[13:7], 1'b0};
      b[base]     = {onehot[20:14], 1'b0};
      if (en) begin
        b[1][7] = addr[0];
        b[0]    = {addr[7:1], 1'b0};
      end
      return b;
    endfunction

    function void note_command(logic cmd, logic [COL_W-1:0] col, logic [ROWS-1:0] pat,
                               logic lvl);
      logic [ROWS-1:0] target, flips;
      int              total, k;
      frame_rec_t      rec;
      if (col >= COLUMNS) begin
        ignored++;
        return;
      end
      if (cmd == CMD_FORCE) begin
        forces++;
        target = {ROWS{lvl}};
        flips  = '1;
      end else begin
        sets++;
        target = pat;
        flips  = image[col] ^ pat;
      end
      total = 3 * $countones(flips);
      k     = 0;
      // ascending rows, three frames per flipped dot
      for (int row = 0; row < ROWS; row++) begin
        if (flips[row]) begin
          for (int p = 0; p < 3; p++) begin
            rec.phase = (p == 0) ? PH_DATA : (p == 1) ? PH_ENABLE : PH_RELEASE;
            rec.frame = build_frame(5'(row), target[row], rec.phase == PH_ENABLE, col);
            rec.row   = ROW_W'(row);
            rec.dir   = target[row];
            k++;
            rec.last  = (k == total);
            frames_due.push_back(rec);
          end
        end
      end
      image[col] = target;
    endfunction

    function void check_frame(logic [63:0] f, logic [1:0] ph, logic [ROW_W-1:0] row,
                              logic dir, logic lst);
      frame_rec_t want;
      frames_seen++;
      if (frames_due.size() == 0) begin
        errors++;
        $error("frame %h arrived with no frame expected", f);
        return;
      end
      want = frames_due.pop_front();
      if (want.frame !== f) begin
        errors++;
        $error("frame: expected %h, got %h", want.frame, f);
      end
      if (want.phase !== ph) begin
        errors++;
        $error("phase: expected %0d, got %0d", want.phase, ph);
      end
      if (want.row !== row) begin
        errors++;
        $error("flip_row: expected %0d, got %0d", want.row, row);
      end
      if (want.dir !== dir) begin
        errors++;
        $error("flip_level: expected %0d, got %0d", want.dir, dir);
      end
      if (want.last !== lst) begin
        errors++;
        $error("last: expected %0d, got %0d", want.last, lst);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 command = CMD_SET;
  logic [COL_W-1:0]     column = '0;
  logic [ROWS-1:0]      pattern = '0;
  logic                 level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [63:0]          frame;
  logic [1:0]           phase;
  logic [ROW_W-1:0]     flip_row;
  logic                 flip_level;
  logic                 last;

  column_frame_predictor board;
  logic [ROWS-1:0]       shown [COLUMNS];
  int                    cycles = 0;
  int                    hold_req = 0;
  int                    settings = 1;
  bit                    idle_on = 1'b1;

  flip_dot_column_diff_driver i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .column     (column),
    .pattern    (pattern),
    .level      (level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame      (frame),
    .phase      (phase),
    .flip_row   (flip_row),
    .flip_level (flip_level),
    .last       (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Observe every transfer on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) board.note_command(command, column, pattern, level);
      if (out_valid && out_ready) board.check_frame(frame, phase, flip_row, flip_level, last);
    end
  end

  // Frame receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = idle_on ? $urandom_range(12, 0) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input logic [3:0] ro, input logic [2:0] co, input logic [7:0] ba);
    write_register(REG_ROW_OFFSET, {4'($urandom), ro});
    write_register(REG_COLUMN_OFFSET, {5'($urandom), co});
    write_register(REG_BOARD_ADDRESS, ba);
    write_register(REG_SPARE, 8'($urandom));
    settings++;
  endtask

  // Offer one command and hold it until the transfer
  task automatic send_command(input logic cmd, input logic [COL_W-1:0] col,
                              input logic [ROWS-1:0] pat, input logic lvl);
    int gap;
    gap = idle_on ? $urandom_range(12, 0) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    command  = cmd;
    column   = col;
    pattern  = pat;
    level    = lvl;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (col < COLUMNS) shown[col] = (cmd == CMD_FORCE) ? {ROWS{lvl}} : pat;
  endtask

  // Stop offering and wait for every predicted frame, then settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.frames_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly in-range columns; some repeats and single-dot changes, some ignored columns
  task automatic run_random(input int want);
    int               done, pick;
    logic             cmd, lvl;
    logic [COL_W-1:0] col;
    logic [ROWS-1:0]  pat;
    done = 0;
    while (done < want) begin
      pick = $urandom_range(99, 0);
      cmd  = ($urandom_range(3, 0) == 0) ? CMD_FORCE : CMD_SET;
      lvl  = 1'($urandom_range(1, 0));
      pat  = ROWS'($urandom);
      if (pick < 8) begin
        col = COL_W'($urandom_range(31, COLUMNS));
      end else begin
        col = COL_W'($urandom_range(COLUMNS - 1, 0));
        if (pick < 20) pat = shown[col];
        else if (pick < 45) pat = shown[col] ^ (13'd1 << $urandom_range(ROWS - 1, 0));
        done++;
      end
      send_command(cmd, col, pat, lvl);
      if (pick == 99) drain();
    end
  endtask

  initial begin
    board = new();
    foreach (shown[i]) shown[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: edge columns and rows, no-change sets, repeated forces, ignored columns
    send_command(CMD_SET,   5'd0,  13'h0000, 1'b0);
    send_command(CMD_SET,   5'd0,  13'h0001, 1'b0);
    send_command(CMD_SET,   5'd0,  13'h0001, 1'b1);
    send_command(CMD_SET,   5'd20, 13'h1fff, 1'b0);
    send_command(CMD_SET,   5'd20, 13'h0aaa, 1'b1);
    send_command(CMD_SET,   5'd10, 13'h1000, 1'b0);
    send_command(CMD_FORCE, 5'd5,  13'h0000, 1'b1);
    send_command(CMD_FORCE, 5'd5,  13'h1fff, 1'b0);
    send_command(CMD_FORCE, 5'd5,  13'h0155, 1'b0);
    send_command(CMD_SET,   5'd21, 13'h1fff, 1'b1);
    send_command(CMD_FORCE, 5'd31, 13'h1fff, 1'b1);
    send_command(CMD_SET,   5'd16, 13'h1555, 1'b0);
    send_command(CMD_FORCE, 5'd0,  13'h0000, 1'b1);
    send_command(CMD_SET,   5'd0,  13'h0000, 1'b1);
    send_command(CMD_SET,   5'd7,  13'h1fff, 1'b0);
    send_command(CMD_FORCE, 5'd7,  13'h1fff, 1'b0);
    run_random(10);
    drain();

    // Zero offsets and address
    apply_setting(4'd0, 3'd0, 8'h00);
    run_random(20);
    drain();

    // Largest offsets: rows past the driver range select nothing
    apply_setting(4'd15, 3'd7, 8'hff);
    idle_on  = 1'b0;
    hold_req = HOLD_OFF_CYCLES;
    repeat (6) send_command(CMD_FORCE, COL_W'($urandom_range(COLUMNS - 1, 0)),
                            ROWS'($urandom), 1'($urandom));
    drain();
    idle_on = 1'b1;
    run_random(15);
    drain();

    // Whole-display wipe at full rate, then random traffic
    apply_setting(4'd8, 3'd0, 8'h55);
    idle_on = 1'b0;
    for (int c = 0; c < COLUMNS; c++) send_command(CMD_FORCE, COL_W'(c), '0, 1'b0);
    idle_on = 1'b1;
    run_random(15);
    drain();

    apply_setting(4'($urandom), 3'($urandom), 8'($urandom));
    run_random(20);
    drain();

    $display("Covered %0d set and %0d force commands, %0d ignored, %0d frames checked",
             board.sets, board.forces, board.ignored, board.frames_seen);
    $display("under %0d register settings, with long receiver hold-off and a full wipe",
             settings);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
